// ----- hw/rtl/svpwm_pkg.sv -----
`default_nettype none
// ============================================================================
// svpwm_pkg
// Shared types, constants and helpers of the space vector PWM timing block.
// ============================================================================
package svpwm_pkg;

    // fixed-point constants, Q1.14
    localparam logic [14:0] K_A = 15'd20066;   // sqrt(3/2)
    localparam logic [14:0] K_B = 15'd11585;   // sqrt(1/2)
    localparam logic [14:0] K_S = 15'd28378;   // sqrt(3)

    // carrier period after reset
    localparam logic [15:0] TC_RESET = 16'd5000;

    // quotient bits of the scaling divider, one pipeline stage per bit
    localparam int P_NDIV = 32;
    // front stages (abs, const mult, period mult, round add) and back stages
    localparam int P_NFRONT = 4;
    localparam int P_NBACK  = 3;
    localparam int P_NSTG   = P_NFRONT + P_NDIV + P_NBACK;

    // area codes
    localparam logic [1:0] AREA_UPPER = 2'd1;
    localparam logic [1:0] AREA_LEFT  = 2'd2;
    localparam logic [1:0] AREA_LOWER = 2'd3;

    // sector codes
    localparam logic [2:0] SECTOR_1 = 3'd1;
    localparam logic [2:0] SECTOR_2 = 3'd2;
    localparam logic [2:0] SECTOR_3 = 3'd3;
    localparam logic [2:0] SECTOR_4 = 3'd4;
    localparam logic [2:0] SECTOR_5 = 3'd5;
    localparam logic [2:0] SECTOR_6 = 3'd6;

    // active vector codes
    localparam logic [2:0] VEC_1 = 3'd1;
    localparam logic [2:0] VEC_2 = 3'd2;
    localparam logic [2:0] VEC_3 = 3'd3;
    localparam logic [2:0] VEC_4 = 3'd4;
    localparam logic [2:0] VEC_5 = 3'd5;
    localparam logic [2:0] VEC_6 = 3'd6;

    localparam logic signed [35:0] TIME_MAX = 36'sd65535;

    // command beat
    typedef struct packed {
        logic signed [15:0] v_alpha;
        logic signed [15:0] v_beta;
        logic        [15:0] dc_voltage;
    } t_cmd;

    // result beat
    typedef struct packed {
        logic [1:0]  area;
        logic [2:0]  sector;
        logic [2:0]  odd_vector;
        logic [2:0]  even_vector;
        logic [15:0] zero_time;
        logic [15:0] odd_time;
        logic [15:0] even_time;
        logic [15:0] on_time_a;
        logic [15:0] on_time_b;
        logic [15:0] on_time_c;
        logic        overmodulated;
    } t_res;

    // classification flags that ride along the pipeline
    typedef struct packed {
        logic neg_a;    // v_alpha < 0
        logic neg_b;    // v_beta < 0
        logic left;     // area 2
        logic above;    // |vb| > sqrt(3)|va|
        logic zdc;      // zero link voltage
    } t_side;

    // clamp a time to 0..65535
    function automatic logic [15:0] sat_time(input logic signed [35:0] t);
        logic [15:0] res;
        if (t < 36'sd0) begin
            res = 16'd0;
        end else if (t > TIME_MAX) begin
            res = 16'hFFFF;
        end else begin
            res = t[15:0];
        end
        return res;
    endfunction

    // time above the 16-bit range
    function automatic logic is_sat(input logic signed [35:0] t);
        return t > TIME_MAX;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/svpwm_cmd_if.sv -----
`default_nettype none
// ============================================================================
// svpwm_cmd_if
// Valid/ready channel carrying one alpha-beta command beat.
// ============================================================================
interface svpwm_cmd_if;
    logic              valid;
    logic              ready;
    svpwm_pkg::t_cmd   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/svpwm_res_if.sv -----
`default_nettype none
// ============================================================================
// svpwm_res_if
// Valid/ready channel carrying one PWM timing result beat.
// ============================================================================
interface svpwm_res_if;
    logic              valid;
    logic              ready;
    svpwm_pkg::t_res   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/space_vector_pwm_timing_top.sv -----
`default_nettype none
// ============================================================================
// space_vector_pwm_timing_top
// Two-level space vector PWM timing: scales an alpha-beta command by the
// carrier period over the link voltage, finds area, sector and vectors, and
// returns phase on-times and zero/odd/even vector durations.
// ============================================================================
// throughput: one beat per cycle while the pipeline is not held; the 32-stage pipelined divider that scales
//   by the link voltage sets the depth, one quotient bit per stage
// the whole pipeline holds while a result beat waits and o_res.ready is low
// reset: synchronous, active low; clears all stage valids, period = 5000
module space_vector_pwm_timing_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    svpwm_cmd_if.sink        i_cmd,
    svpwm_res_if.source      o_res
);

    localparam int ND   = svpwm_pkg::P_NDIV;
    localparam int LAST = svpwm_pkg::P_NSTG - 1;

    // carrier period register
    logic [15:0] r_tc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc <= svpwm_pkg::TC_RESET;
        end else if (i_cfg_we) begin
            r_tc <= i_cfg_wdata;
        end
    end

    // pipeline advance and stage valids
    logic                         w_en;
    logic                         w_fire;
    logic [svpwm_pkg::P_NSTG-1:0] r_vld;
    logic [svpwm_pkg::P_NSTG-1:0] n_vld;

    assign w_en        = !(r_vld[LAST] && !o_res.ready);
    assign i_cmd.ready = w_en;
    assign w_fire      = i_cmd.valid && w_en;
    assign n_vld       = {r_vld[LAST-1:0], w_fire};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= n_vld;
        end
    end

    // stage 0: magnitudes and signs
    logic [15:0]      w0_ava;
    logic [15:0]      w0_avb;
    logic [15:0]      r0_ava;
    logic [15:0]      r0_avb;
    logic [15:0]      r0_vdc;
    svpwm_pkg::t_side r0_side;

    assign w0_ava = i_cmd.data.v_alpha[15] ? (~i_cmd.data.v_alpha + 16'd1)
                                           : i_cmd.data.v_alpha;
    assign w0_avb = i_cmd.data.v_beta[15] ? (~i_cmd.data.v_beta + 16'd1)
                                          : i_cmd.data.v_beta;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_ava        <= w0_ava;
            r0_avb        <= w0_avb;
            r0_vdc        <= i_cmd.data.dc_voltage;
            r0_side.neg_a <= i_cmd.data.v_alpha[15];
            r0_side.neg_b <= i_cmd.data.v_beta[15];
            r0_side.left  <= 1'b0;
            r0_side.above <= 1'b0;
            r0_side.zdc   <= (i_cmd.data.dc_voltage == 16'd0);
        end
    end

    // stage 1: constant multiplies
    logic [29:0]      w1_pa;
    logic [29:0]      w1_pb;
    logic [29:0]      w1_ks;
    logic [29:0]      r1_pa;
    logic [28:0]      r1_pb;
    logic [29:0]      r1_ks;
    logic [15:0]      r1_avb;
    logic [15:0]      r1_vdc;
    svpwm_pkg::t_side r1_side;

    assign w1_pa = {14'd0, r0_ava} * {15'd0, svpwm_pkg::K_A};
    assign w1_pb = {14'd0, r0_avb} * {15'd0, svpwm_pkg::K_B};
    assign w1_ks = {14'd0, r0_ava} * {15'd0, svpwm_pkg::K_S};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_pa   <= w1_pa;
            r1_pb   <= w1_pb[28:0];
            r1_ks   <= w1_ks;
            r1_avb  <= r0_avb;
            r1_vdc  <= r0_vdc;
            r1_side <= r0_side;
        end
    end

    // stage 2: period multiplies and area compare
    logic [45:0]      w2_na;
    logic [45:0]      w2_nb;
    logic [29:0]      w2_bs;
    svpwm_pkg::t_side w2_side;
    logic [45:0]      r2_na;
    logic [45:0]      r2_nb;
    logic [15:0]      r2_vdc;
    svpwm_pkg::t_side r2_side;

    assign w2_na = {16'd0, r1_pa} * {30'd0, r_tc};
    assign w2_nb = {17'd0, r1_pb} * {30'd0, r_tc};
    assign w2_bs = {r1_avb, 14'd0};

    // side flags with the area compare filled in
    always_comb begin
        w2_side       = r1_side;
        w2_side.left  = r1_side.neg_a && (w2_bs < r1_ks);
        w2_side.above = (w2_bs > r1_ks);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_na   <= w2_na;
            r2_nb   <= w2_nb;
            r2_vdc  <= r1_vdc;
            r2_side <= w2_side;
        end
    end

    // stage 3: round to nearest, fold the 2^14 into the dividend
    logic [45:0]       w3_suma;
    logic [45:0]       w3_sumb;
    logic [ND-1:0]     r_dqa  [0:ND];
    logic [ND-1:0]     r_dqb  [0:ND];
    logic [15:0]       r_rema [0:ND];
    logic [15:0]       r_remb [0:ND];
    logic [15:0]       r_dvs  [0:ND];
    svpwm_pkg::t_side  r_dside [0:ND];

    assign w3_suma = r2_na + {17'd0, r2_vdc, 13'd0};
    assign w3_sumb = r2_nb + {17'd0, r2_vdc, 13'd0};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dqa[0]   <= w3_suma[45:14];
            r_dqb[0]   <= w3_sumb[45:14];
            r_rema[0]  <= 16'd0;
            r_remb[0]  <= 16'd0;
            r_dvs[0]   <= r2_vdc;
            r_dside[0] <= r2_side;
        end
    end

    // divider stages: restoring, one quotient bit per stage
    for (genvar j = 0; j < ND; j++) begin : g_div
        logic [16:0] w_ra;
        logic [16:0] w_rb;
        logic        w_ga;
        logic        w_gb;

        assign w_ra = {r_rema[j], r_dqa[j][ND-1]};
        assign w_rb = {r_remb[j], r_dqb[j][ND-1]};
        assign w_ga = (w_ra >= {1'b0, r_dvs[j]});
        assign w_gb = (w_rb >= {1'b0, r_dvs[j]});

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rema[j+1]  <= w_ga ? 16'(w_ra - {1'b0, r_dvs[j]}) : w_ra[15:0];
                r_remb[j+1]  <= w_gb ? 16'(w_rb - {1'b0, r_dvs[j]}) : w_rb[15:0];
                r_dqa[j+1]   <= {r_dqa[j][ND-2:0], w_ga};
                r_dqb[j+1]   <= {r_dqb[j][ND-2:0], w_gb};
                r_dvs[j+1]   <= r_dvs[j];
                r_dside[j+1] <= r_dside[j];
            end
        end
    end

    // stage T0: signed components, area, sector, phase on-times
    svpwm_pkg::t_side  w4_side;
    logic [ND-1:0]     w4_aza;
    logic [ND-1:0]     w4_azb;
    logic signed [34:0] w4_aza35;
    logic signed [34:0] w4_azb35;
    logic signed [34:0] w4_za;
    logic signed [34:0] w4_zb;
    logic [1:0]        w4_area;
    logic [2:0]        w4_sector;
    logic [2:0]        w4_odd;
    logic [2:0]        w4_even;
    logic signed [34:0] w4_ta;
    logic signed [34:0] w4_tb;
    logic signed [34:0] w4_tc;
    logic signed [34:0] w4_first;
    logic signed [34:0] w4_second;

    assign w4_side  = r_dside[ND];
    assign w4_aza   = w4_side.zdc ? '0 : r_dqa[ND];
    assign w4_azb   = w4_side.zdc ? '0 : r_dqb[ND];
    assign w4_aza35 = signed'({3'b000, w4_aza});
    assign w4_azb35 = signed'({3'b000, w4_azb});
    assign w4_za    = w4_side.neg_a ? -w4_aza35 : w4_aza35;
    assign w4_zb    = w4_side.neg_b ? -w4_azb35 : w4_azb35;

    always_comb begin
        priority if (w4_side.left) begin
            w4_area = svpwm_pkg::AREA_LEFT;
            if (!w4_side.neg_b) begin
                w4_sector = svpwm_pkg::SECTOR_3;
                w4_odd    = svpwm_pkg::VEC_3;
            end else begin
                w4_sector = svpwm_pkg::SECTOR_4;
                w4_odd    = svpwm_pkg::VEC_5;
            end
            w4_even   = svpwm_pkg::VEC_4;
            w4_ta     = 35'sd0;
            w4_tb     = w4_aza35 + w4_zb;
            w4_tc     = w4_aza35 - w4_zb;
            w4_first  = w4_tb;
            w4_second = w4_tc;
        end else if (!w4_side.neg_b) begin
            w4_area = svpwm_pkg::AREA_UPPER;
            if (w4_side.above) begin
                w4_sector = svpwm_pkg::SECTOR_2;
                w4_odd    = svpwm_pkg::VEC_3;
            end else begin
                w4_sector = svpwm_pkg::SECTOR_1;
                w4_odd    = svpwm_pkg::VEC_1;
            end
            w4_even   = svpwm_pkg::VEC_2;
            w4_ta     = w4_za + w4_azb35;
            w4_tb     = w4_azb35 <<< 1;
            w4_tc     = 35'sd0;
            w4_first  = w4_ta;
            w4_second = w4_tb;
        end else begin
            w4_area = svpwm_pkg::AREA_LOWER;
            if (w4_side.above) begin
                w4_sector = svpwm_pkg::SECTOR_5;
                w4_odd    = svpwm_pkg::VEC_5;
            end else begin
                w4_sector = svpwm_pkg::SECTOR_6;
                w4_odd    = svpwm_pkg::VEC_1;
            end
            w4_even   = svpwm_pkg::VEC_6;
            w4_ta     = w4_za + w4_azb35;
            w4_tb     = 35'sd0;
            w4_tc     = w4_azb35 <<< 1;
            w4_first  = w4_tc;
            w4_second = w4_ta;
        end
    end

    logic [1:0]         r4_area;
    logic [2:0]         r4_sector;
    logic [2:0]         r4_odd;
    logic [2:0]         r4_even;
    logic signed [34:0] r4_ta;
    logic signed [34:0] r4_tb;
    logic signed [34:0] r4_tc;
    logic signed [34:0] r4_first;
    logic signed [34:0] r4_second;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_area   <= w4_area;
            r4_sector <= w4_sector;
            r4_odd    <= w4_odd;
            r4_even   <= w4_even;
            r4_ta     <= w4_ta;
            r4_tb     <= w4_tb;
            r4_tc     <= w4_tc;
            r4_first  <= w4_first;
            r4_second <= w4_second;
        end
    end

    // stage T1: longest and shorter on-time, first one wins a tie
    logic               w5_ge;
    logic [1:0]         r5_area;
    logic [2:0]         r5_sector;
    logic [2:0]         r5_odd;
    logic [2:0]         r5_even;
    logic signed [34:0] r5_ta;
    logic signed [34:0] r5_tb;
    logic signed [34:0] r5_tc;
    logic signed [34:0] r5_lng;
    logic signed [34:0] r5_shr;

    assign w5_ge = (r4_first >= r4_second);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_area   <= r4_area;
            r5_sector <= r4_sector;
            r5_odd    <= r4_odd;
            r5_even   <= r4_even;
            r5_ta     <= r4_ta;
            r5_tb     <= r4_tb;
            r5_tc     <= r4_tc;
            r5_lng    <= w5_ge ? r4_first : r4_second;
            r5_shr    <= w5_ge ? r4_second : r4_first;
        end
    end

    // stage T2: durations, saturation and overmodulation into the result beat
    logic signed [35:0] w6_lng;
    logic signed [35:0] w6_shr;
    logic signed [35:0] w6_ta;
    logic signed [35:0] w6_tb;
    logic signed [35:0] w6_tc;
    logic signed [35:0] w6_zt;
    logic signed [35:0] w6_od;
    logic               w6_sat;
    svpwm_pkg::t_res    r_res;

    assign w6_lng = {r5_lng[34], r5_lng};
    assign w6_shr = {r5_shr[34], r5_shr};
    assign w6_ta  = {r5_ta[34], r5_ta};
    assign w6_tb  = {r5_tb[34], r5_tb};
    assign w6_tc  = {r5_tc[34], r5_tc};
    assign w6_zt  = signed'({20'd0, r_tc}) - w6_lng;
    assign w6_od  = w6_lng - w6_shr;
    assign w6_sat = svpwm_pkg::is_sat(w6_zt) || svpwm_pkg::is_sat(w6_od)
                 || svpwm_pkg::is_sat(w6_shr) || svpwm_pkg::is_sat(w6_ta)
                 || svpwm_pkg::is_sat(w6_tb) || svpwm_pkg::is_sat(w6_tc);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_res.area          <= r5_area;
            r_res.sector        <= r5_sector;
            r_res.odd_vector    <= r5_odd;
            r_res.even_vector   <= r5_even;
            r_res.zero_time     <= svpwm_pkg::sat_time(w6_zt);
            r_res.odd_time      <= svpwm_pkg::sat_time(w6_od);
            r_res.even_time     <= svpwm_pkg::sat_time(w6_shr);
            r_res.on_time_a     <= svpwm_pkg::sat_time(w6_ta);
            r_res.on_time_b     <= svpwm_pkg::sat_time(w6_tb);
            r_res.on_time_c     <= svpwm_pkg::sat_time(w6_tc);
            r_res.overmodulated <= w6_sat || (w6_zt < 36'sd0);
        end
    end

    assign o_res.valid = r_vld[LAST];
    assign o_res.data  = r_res;

`ifndef NO_ASSERTIONS
    // a stalled pipeline keeps every stage valid where it is
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> (r_vld == $past(r_vld)))
        else $error("stage valids moved during a stall");

    // left half only lives in sectors three and four
    a_left_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAST] && r_res.area == svpwm_pkg::AREA_LEFT) |->
        (r_res.sector == svpwm_pkg::SECTOR_3 || r_res.sector == svpwm_pkg::SECTOR_4))
        else $error("left area with wrong sector");

    // sectors one and six use odd vector one
    a_odd_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAST] && (r_res.sector == svpwm_pkg::SECTOR_1 ||
                         r_res.sector == svpwm_pkg::SECTOR_6)) |->
        (r_res.odd_vector == svpwm_pkg::VEC_1))
        else $error("odd vector does not match sector");

    // the phase that idles in each area has zero on-time
    a_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[LAST] |->
        ((r_res.area == svpwm_pkg::AREA_LEFT  && r_res.on_time_a == 16'd0) ||
         (r_res.area == svpwm_pkg::AREA_UPPER && r_res.on_time_c == 16'd0) ||
         (r_res.area == svpwm_pkg::AREA_LOWER && r_res.on_time_b == 16'd0)))
        else $error("idle phase has nonzero on-time");
`endif

endmodule
`default_nettype wire
